[rtl/poav_pkg.sv]
`timescale 1ns / 1ps

package poav_pkg;

    localparam int MAX_READINGS = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int COUNT_W    = $clog2(MAX_READINGS + 1);
    localparam int STEP_W     = $clog2(ATAN_ENTRIES);
    localparam int SUM_W      = 20;
    localparam int SQ_W       = 2 * SUM_W;
    localparam int CW         = 36;
    localparam int ZW         = 34;
    localparam int ANG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] GAIN_Q16 = 16'd39797;

    localparam logic signed [ZW-1:0] HALF_TURN = {{(ZW-32){1'b0}}, 1'b1, 31'b0};

    localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 2'd2;

    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [12:0]        strength;
        logic signed [15:0] bearing;
        logic               last_reading;
    } reading_t;

    typedef struct packed {
        logic [15:0] left_speed;
        logic [15:0] right_speed;
    } steer_t;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_cmd_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_res_t;

endpackage

[rtl/poav_cordic.sv]
`timescale 1ns / 1ps

module poav_cordic import poav_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_cmd_t          cmd,
    input  logic signed [CW-1:0] x_init,
    input  logic signed [CW-1:0] y_init,
    input  logic signed [ZW-1:0] z_init,
    output cordic_res_t          res
);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 rotate_reg, rotate_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] atan_z;
    logic                 pos_dir;
    logic                 last_step;

    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_z    = signed'({{(ZW-32){1'b0}}, ATAN_TABLE[step_reg]});
    // rotation steers z to zero, vectoring steers y to zero
    assign pos_dir   = rotate_reg ? !z_reg[ZW-1] : y_reg[CW-1];
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        rotate_next = rotate_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        if (cmd.start)
        begin
            x_next      = x_init;
            y_next      = y_init;
            z_next      = z_init;
            rotate_next = cmd.rotate;
            run_next    = 1'b1;
            step_next   = '0;
        end
        else if (run_reg)
        begin
            if (pos_dir)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            step_next = step_reg + 1'b1;
            if (last_step)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_reg <= 1'b0;
            run_reg    <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            rotate_reg <= rotate_next;
            run_reg    <= run_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign res.done = done_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;
    assign res.z    = z_reg;

endmodule

[rtl/poav_sqr.sv]
`timescale 1ns / 1ps

module poav_sqr import poav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  operand,
    output logic [SQ_W-1:0]   square,
    output logic              done
);

    localparam int BIT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] mcand_reg, mcand_next;
    logic [SUM_W-1:0] hi_reg, hi_next;
    logic [SUM_W-1:0] lo_reg, lo_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    logic [SUM_W:0]   part_sum;

    // one multiplier bit per cycle, lsb first
    assign part_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        bit_next   = bit_reg;
        if (start)
        begin
            mcand_next = operand;
            hi_next    = '0;
            lo_next    = operand;
            run_next   = 1'b1;
            bit_next   = '0;
        end
        else if (run_reg)
        begin
            hi_next  = part_sum[SUM_W:1];
            lo_next  = {part_sum[0], lo_reg[SUM_W-1:1]};
            bit_next = bit_reg + 1'b1;
            if (bit_reg == BIT_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign square = {hi_reg, lo_reg};
    assign done   = done_reg;

endmodule

[rtl/proximity_obstacle_avoid_steer_core.sv]
`timescale 1ns / 1ps
// a reading that is accumulated holds off the input through rotation and accumulation:
// no new reading is taken before it is through, set by the single iterative CORDIC unit
// a last reading gives its steering beat after rotation and accumulation, then the
// vectoring pass alongside three bit-serial squarers, then the decision
// an extra reading beyond the limit that is not last is taken without a stall and dropped
// reset is asynchronous: sums and count clear, registers load their defaults

module proximity_obstacle_avoid_steer_core import poav_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  reading_valid,
    output logic                  reading_stall,
    input  reading_t              reading,
    output logic                  steer_valid,
    input  logic                  steer_stall,
    output steer_t                steer,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_VST  = 3'd3;
    localparam logic [2:0] S_VEC  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    localparam int LIM_W = 13 + COUNT_W;

    logic [2:0]              state_reg, state_next;
    logic [14:0]             half_angle_reg;
    logic [12:0]             near_reg;
    logic [15:0]             speed_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    last_reg, last_next;
    logic                    vdone_reg, vdone_next;
    logic                    sdone_reg, sdone_next;
    logic                    out_valid_reg, out_valid_next;
    steer_t                  out_reg, out_next;
    logic signed [SUM_W-1:0] vx_reg, vx_next;
    logic signed [SUM_W-1:0] vy_reg, vy_next;

    logic                    accept;
    logic                    room;
    logic                    wrap;
    logic signed [15:0]      bearing_adj;
    logic [28:0]             scaled;
    logic signed [CW-1:0]    scaled_s;
    logic signed [CW-1:0]    rot_x;
    logic signed [ZW-1:0]    rot_z;
    logic signed [CW-1:0]    sx_wide;
    logic signed [CW-1:0]    sy_wide;
    logic signed [CW-1:0]    vec_x;
    logic signed [CW-1:0]    vec_y;
    logic signed [ZW-1:0]    vec_z;
    logic signed [CW-1:0]    x_init;
    logic signed [CW-1:0]    y_init;
    logic signed [ZW-1:0]    z_init;
    cordic_cmd_t             ccmd;
    cordic_res_t             cres;
    logic signed [CW-1:0]    rnd_x;
    logic signed [CW-1:0]    rnd_y;
    logic                    sq_start;
    logic [SUM_W-1:0]        mag_x;
    logic [SUM_W-1:0]        mag_y;
    logic [LIM_W-1:0]        lim_prod;
    logic [SQ_W-1:0]         sq_x;
    logic [SQ_W-1:0]         sq_y;
    logic [SQ_W-1:0]         sq_lim;
    logic                    sq_done;
    logic                    sqy_done;
    logic                    sql_done;
    logic [SQ_W:0]           len2;
    logic signed [ZW-1:0]    z_round;
    logic signed [ZW-1:0]    z_shift;
    logic signed [ANG_W-1:0] ang;
    logic signed [ANG_W-1:0] alpha;
    logic                    straight;
    logic                    positive;
    logic                    out_free;

    assign reading_stall = (state_reg != S_IDLE);
    assign accept        = reading_valid && !reading_stall;
    assign room          = (count_reg < COUNT_W'(MAX_READINGS));

    // rotation start: fold the bearing into the right half plane
    assign wrap        = (reading.bearing > 16'sd16384) || (reading.bearing < -16'sd16384);
    assign bearing_adj = wrap ? {~reading.bearing[15], reading.bearing[14:0]}
                              : reading.bearing;
    assign scaled      = 29'(reading.strength) * 29'(GAIN_Q16);
    assign scaled_s    = signed'({{(CW-29){1'b0}}, scaled});
    assign rot_x       = wrap ? -scaled_s : scaled_s;
    assign rot_z       = {{(ZW-32){bearing_adj[15]}}, bearing_adj, 16'b0};

    // vectoring start: sums scaled by 2^14, left half plane mirrored
    assign sx_wide = {{(CW-SUM_W-14){sum_x_reg[SUM_W-1]}}, sum_x_reg, 14'b0};
    assign sy_wide = {{(CW-SUM_W-14){sum_y_reg[SUM_W-1]}}, sum_y_reg, 14'b0};
    assign vec_x   = sum_x_reg[SUM_W-1] ? -sx_wide : sx_wide;
    assign vec_y   = sum_x_reg[SUM_W-1] ? -sy_wide : sy_wide;
    assign vec_z   = !sum_x_reg[SUM_W-1] ? '0
                   : (sum_y_reg > 0) ? HALF_TURN : -HALF_TURN;

    assign x_init = (state_reg == S_VST) ? vec_x : rot_x;
    assign y_init = (state_reg == S_VST) ? vec_y : '0;
    assign z_init = (state_reg == S_VST) ? vec_z : rot_z;

    assign ccmd.start  = (accept && room) || (state_reg == S_VST);
    assign ccmd.rotate = (state_reg == S_IDLE);

    poav_cordic u_cordic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ccmd),
        .x_init (x_init),
        .y_init (y_init),
        .z_init (z_init),
        .res    (cres)
    );

    // round half away from zero to q1.12
    assign rnd_x = cres.x + {{(CW-16){1'b0}}, (cres.x[CW-1] ? 16'h7FFF : 16'h8000)};
    assign rnd_y = cres.y + {{(CW-16){1'b0}}, (cres.y[CW-1] ? 16'h7FFF : 16'h8000)};

    assign sq_start = (state_reg == S_VST);
    assign mag_x    = sum_x_reg[SUM_W-1] ? unsigned'(-sum_x_reg) : unsigned'(sum_x_reg);
    assign mag_y    = sum_y_reg[SUM_W-1] ? unsigned'(-sum_y_reg) : unsigned'(sum_y_reg);
    assign lim_prod = LIM_W'(near_reg) * LIM_W'(count_reg);

    poav_sqr u_sqr_x
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (mag_x),
        .square  (sq_x),
        .done    (sq_done)
    );

    poav_sqr u_sqr_y
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (mag_y),
        .square  (sq_y),
        .done    (sqy_done)
    );

    poav_sqr u_sqr_lim
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (SUM_W'(lim_prod)),
        .square  (sq_lim),
        .done    (sql_done)
    );

    // decision
    assign len2     = {1'b0, sq_x} + {1'b0, sq_y};
    assign z_round  = cres.z + {{(ZW-16){1'b0}}, 16'h8000};
    assign z_shift  = z_round >>> 16;
    assign ang      = (sum_y_reg == '0) ? (sum_x_reg[SUM_W-1] ? 17'sd32768 : 17'sd0)
                                        : z_shift[ANG_W-1:0];
    assign alpha    = signed'({2'b00, half_angle_reg});
    assign straight = (ang >= -alpha) && (ang <= alpha) && (len2 < {1'b0, sq_lim});
    assign positive = (ang > 0);
    assign out_free = !out_valid_reg || !steer_stall;

    always_comb
    begin
        state_next     = state_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        vdone_next     = vdone_reg;
        sdone_next     = sdone_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        if (out_valid_reg && !steer_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = reading.last_reading;
                    if (room)
                    begin
                        state_next = S_ROT;
                    end
                    else if (reading.last_reading)
                    begin
                        state_next = S_VST;
                    end
                end
            end
            S_ROT:
            begin
                if (cres.done)
                begin
                    vx_next    = rnd_x[SUM_W+15:16];
                    vy_next    = rnd_y[SUM_W+15:16];
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_x_next = sum_x_reg + vx_reg;
                sum_y_next = sum_y_reg + vy_reg;
                count_next = count_reg + 1'b1;
                state_next = last_reg ? S_VST : S_IDLE;
            end
            S_VST:
            begin
                vdone_next = 1'b0;
                sdone_next = 1'b0;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                if (cres.done)
                begin
                    vdone_next = 1'b1;
                end
                if (sq_done && sqy_done && sql_done)
                begin
                    sdone_next = 1'b1;
                end
                if (vdone_reg && sdone_reg)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.left_speed  = (straight || positive) ? speed_reg : 16'd0;
                    out_next.right_speed = (straight || !positive) ? speed_reg : 16'd0;
                    sum_x_next           = '0;
                    sum_y_next           = '0;
                    count_next           = '0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            vdone_reg     <= 1'b0;
            sdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            vdone_reg     <= vdone_next;
            sdone_reg     <= sdone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_angle_reg <= 15'd1820;
            near_reg       <= 13'd2048;
            speed_reg      <= 16'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_ANGLE: half_angle_reg <= cfg_data[14:0];
                REG_NEAR:       near_reg       <= cfg_data[12:0];
                REG_SPEED:      speed_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign steer_valid = out_valid_reg;
    assign steer       = out_reg;

endmodule

[rtl/poav_checker.sv]
`timescale 1ns / 1ps

module poav_checker import poav_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   reading_valid,
    input logic   reading_stall,
    input logic   steer_valid,
    input logic   steer_stall,
    input steer_t steer
);

    // a stalled beat holds
    a_steer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && steer_stall |=> steer_valid && $stable(steer))
        else $error("steer beat changed under stall");

    // straight drives both wheels alike, a turn leaves one wheel at zero
    a_wheel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid |-> (steer.left_speed == steer.right_speed)
                     || (steer.left_speed == 16'd0)
                     || (steer.right_speed == 16'd0))
        else $error("wheel commands inconsistent");

    // a decision is only made while the reading side is held off
    a_decide_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(steer_valid) |-> $past(reading_stall))
        else $error("steer beat without a busy decision");

    // a pending reading keeps its request while held off
    a_reading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reading_valid && reading_stall |=> reading_valid)
        else $error("reading valid dropped under stall");

endmodule

bind proximity_obstacle_avoid_steer_core poav_checker u_poav_checker (.*);

[verif/tb_proximity_obstacle_avoid_steer_core.sv]
`timescale 1ns / 1ps

module tb_proximity_obstacle_avoid_steer_core;
    import poav_pkg::*;

    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          ITEMS_PER_SET  = 134;
    localparam int          ROT_ENTRIES    = 24;
    localparam longint      ANGLE_HALF     = 64'sd2147483648;
    localparam longint      ANGLE_QUARTER  = 64'sd1073741824;
    localparam longint      CORDIC_GAIN    = 64'sd39797;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam longint ROT_ANGLE [ROT_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef enum logic {ROW_READ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [12:0]            strength;
        logic signed [15:0]     bearing;
        logic                   last_reading;
        logic [5:0]             reps;
        logic                   typed;
        steer_t                 want;
        logic [CFG_IDX_W-1:0]   cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_value;
    } dir_row_t;

    localparam int N_ROWS = 24;

    localparam dir_row_t DIRECTED [N_ROWS] = '{
        '{ROW_READ, 13'd0,    16'sd0,      1'b1, 6'd1,  1'b1, '{16'd640, 16'd640},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd4096, 16'sd16384,  1'b1, 6'd1,  1'b1, '{16'd640, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd4096, -16'sd16384, 1'b1, 6'd1,  1'b1, '{16'd0, 16'd640},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd4096, 16'sd0,      1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd8191, -16'sd32768, 1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd8191, 16'sd32767,  1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd4096, 16'sd1820,   1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd1000, -16'sd1820,  1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd2000, 16'sd0,      1'b0, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd2000, -16'sd32768, 1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        // overfull step, the dropped last beat still decides
        '{ROW_READ, 13'd4096, 16'sd16384,  1'b0, 6'd25, 1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_READ, 13'd4096, -16'sd16384, 1'b1, 6'd1,  1'b1, '{16'd640, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_NEAR, 16'd0},
        '{ROW_READ, 13'd0,    16'sd0,      1'b1, 6'd1,  1'b1, '{16'd0, 16'd640},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_SPEED, 16'd65535},
        '{ROW_READ, 13'd4096, 16'sd16384,  1'b1, 6'd1,  1'b1, '{16'd65535, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd32767},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_NEAR, 16'd4096},
        '{ROW_READ, 13'd100,  -16'sd30000, 1'b1, 6'd1,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_SPEED, 16'd0},
        '{ROW_READ, 13'd4096, -16'sd16384, 1'b1, 6'd1,  1'b1, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd0},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_HALF_ANGLE, 16'd1820},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_NEAR, 16'd2048},
        '{ROW_CFG,  13'd0,    16'sd0,      1'b0, 6'd0,  1'b0, '{16'd0, 16'd0},
          REG_SPEED, 16'd640}
    };

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  reading_valid = 1'b0;
    logic                  reading_stall;
    reading_t              reading       = '0;
    logic                  steer_valid;
    logic                  steer_stall   = 1'b0;
    steer_t                steer;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int          send_gap_pct   = 26;
    int          recv_stall_pct = 49;
    int          error_count    = 0;
    int unsigned cycle_count;

    int          cone_half   = 1820;
    int          near_limit  = 2048;
    logic [15:0] drive_speed = 16'd640;
    int          acc_x       = 0;
    int          acc_y       = 0;
    int          acc_count   = 0;

    steer_t pending_steer_q [$];

    proximity_obstacle_avoid_steer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .reading_valid (reading_valid),
        .reading_stall (reading_stall),
        .reading       (reading),
        .steer_valid   (steer_valid),
        .steer_stall   (steer_stall),
        .steer         (steer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void reading_to_xy(input logic [12:0] s, input logic signed [15:0] b,
                                          output int vx, output int vy);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(s) * CORDIC_GAIN;
        y = 0;
        z = longint'(b) * 65536;
        if (z > ANGLE_QUARTER)
        begin
            x = -x;
            z = z - ANGLE_HALF;
        end
        else if (z < -ANGLE_QUARTER)
        begin
            x = -x;
            z = z + ANGLE_HALF;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ROT_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLE[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLE[i];
            end
        end
        // round half away from zero to q1.12
        vx = (x >= 0) ? int'((x + 32768) >>> 16) : int'(-((-x + 32768) >>> 16));
        vy = (y >= 0) ? int'((y + 32768) >>> 16) : int'(-((-y + 32768) >>> 16));
    endfunction

    function automatic int heading_of_sum(input int sx, input int sy);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        if (sy == 0)
            return (sx < 0) ? 32768 : 0;
        x = longint'(sx) * 16384;
        y = longint'(sy) * 16384;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = (sy > 0) ? ANGLE_HALF : -ANGLE_HALF;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ROT_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLE[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLE[i];
            end
        end
        return int'((z + 32768) >>> 16);
    endfunction

    function automatic void steer_from_reading(input reading_t r, output logic produces,
                                               output steer_t cmd);
        int     vx;
        int     vy;
        int     heading;
        longint len_sq;
        longint reach;
        produces = 1'b0;
        cmd      = '0;
        if (acc_count < MAX_READINGS)
        begin
            reading_to_xy(r.strength, r.bearing, vx, vy);
            acc_x     = acc_x + vx;
            acc_y     = acc_y + vy;
            acc_count = acc_count + 1;
        end
        if (r.last_reading)
        begin
            heading = heading_of_sum(acc_x, acc_y);
            len_sq  = longint'(acc_x) * acc_x + longint'(acc_y) * acc_y;
            reach   = longint'(near_limit) * acc_count;
            reach   = reach * reach;
            if (heading >= -cone_half && heading <= cone_half && len_sq < reach)
                cmd = '{drive_speed, drive_speed};
            else if (heading > 0)
                cmd = '{drive_speed, 16'd0};
            else
                cmd = '{16'd0, drive_speed};
            produces  = 1'b1;
            acc_x     = 0;
            acc_y     = 0;
            acc_count = 0;
        end
    endfunction

    task automatic send_reading(input reading_t r, input logic typed, input steer_t want);
        logic   produces;
        steer_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            reading_valid <= 1'b0;
            @(posedge clk);
        end
        reading_valid <= 1'b1;
        reading       <= r;
        @(posedge clk);
        while (reading_stall)
            @(posedge clk);
        steer_from_reading(r, produces, predicted);
        if (produces)
            pending_steer_q.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HALF_ANGLE: cone_half   = int'(value[14:0]);
            REG_NEAR:       near_limit  = int'(value[12:0]);
            REG_SPEED:      drive_speed = value;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // results drained, then room for a dropped reading still in flight
    task automatic wait_idle();
        reading_valid <= 1'b0;
        while (pending_steer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input int sel);
        case (sel)
            0:
            begin
                write_reg(REG_HALF_ANGLE, 16'd1820);
                write_reg(REG_NEAR, 16'd2048);
                write_reg(REG_SPEED, 16'd640);
            end
            1:
            begin
                write_reg(REG_HALF_ANGLE, 16'd0);
                write_reg(REG_NEAR, 16'd0);
                write_reg(REG_SPEED, 16'd1);
            end
            2:
            begin
                write_reg(REG_HALF_ANGLE, 16'd32767);
                write_reg(REG_NEAR, 16'd4096);
                write_reg(REG_SPEED, 16'd65535);
            end
            default:
            begin
                write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
                write_reg(REG_HALF_ANGLE, 16'($urandom_range(0, 32767)));
                write_reg(REG_NEAR, 16'($urandom_range(0, 4096)));
                write_reg(REG_SPEED, 16'($urandom_range(0, 65535)));
            end
        endcase
    endtask

    task automatic run_random_steps(input int target);
        int       counted;
        int       len;
        int       mode;
        int       center;
        int       spread;
        int       b;
        int       sel;
        reading_t r;
        counted = 0;
        while (counted < target)
        begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
            mode   = $urandom_range(0, 3);
            center = $urandom_range(0, 65535);
            spread = $urandom_range(0, 8000);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0: b = $urandom_range(0, 65535);
                    1: b = center + $urandom_range(0, 2 * spread) - spread;
                    2: b = $urandom_range(0, 4000) - 2000;
                    default:
                        case ($urandom_range(0, 5))
                            0: b = -32768;
                            1: b = -16384;
                            2: b = 0;
                            3: b = 16384;
                            4: b = 32767;
                            default: b = $urandom_range(0, 65535);
                        endcase
                endcase
                sel = $urandom_range(0, 31);
                r.bearing = 16'(b);
                if (sel == 0)
                    r.strength = 13'd0;
                else if (sel == 1)
                    r.strength = 13'd4096;
                else if (sel < 4)
                    r.strength = 13'($urandom_range(4097, 8191));
                else if (mode == 2)
                    r.strength = 13'($urandom_range(0, 600));
                else
                    r.strength = 13'($urandom_range(0, 4096));
                r.last_reading = (k == len - 1);
                send_reading(r, 1'b0, '0);
                if (k < MAX_READINGS || r.last_reading)
                    counted++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        steer_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        steer_t want;
        if (rst_n && steer_valid && !steer_stall)
        begin
            if (pending_steer_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected steer beat: left %0d right %0d",
                             steer.left_speed, steer.right_speed);
            end
            else
            begin
                want = pending_steer_q.pop_front();
                if (steer.left_speed !== want.left_speed
                    || steer.right_speed !== want.right_speed)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"steer mismatch: expected left %0d right %0d, ",
                                  "got left %0d right %0d"},
                                 want.left_speed, want.right_speed,
                                 steer.left_speed, steer.right_speed);
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        reading_t r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(DIRECTED[i].cfg_index, DIRECTED[i].cfg_value);
            end
            else
            begin
                for (int k = 0; k < DIRECTED[i].reps; k++)
                begin
                    r.strength     = DIRECTED[i].strength;
                    r.bearing      = DIRECTED[i].bearing;
                    r.last_reading = DIRECTED[i].last_reading && (k == DIRECTED[i].reps - 1);
                    send_reading(r, DIRECTED[i].typed && r.last_reading, DIRECTED[i].want);
                end
            end
        end
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            send_gap_pct   = (p == 0) ? 26 : (p == 1) ? 49 : 0;
            recv_stall_pct = (p == 0) ? 49 : (p == 1) ? 26 : 0;
            for (int s = 0; s < 4; s++)
            begin
                apply_setting(s);
                run_random_steps(ITEMS_PER_SET);
                wait_idle();
            end
        end

        if (pending_steer_q.size() != 0)
        begin
            error_count += pending_steer_q.size();
            $display("%0d steer beats never arrived", pending_steer_q.size());
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
